@@ rtl/core/tqps_pkg.sv @@
// Shared types, constants and blend arithmetic for the textured quad pixel shader.
// No dependencies; every other file imports this package.
package tqps_pkg;

    localparam int TEX_DEPTH_DEF  = 16384;
    localparam int COORD_BITS_DEF = 12;

    localparam int CFG_AW   = 5;
    localparam int DX_W     = 18;   // 16*pixel - origin
    localparam int PROD_W   = 34;   // dx * axis component
    localparam int DUV_W    = 35;   // du, dv
    localparam int UV_W     = 57;   // du * reciprocal
    localparam int UV_FRAC  = 38;
    localparam int TPROD_W  = 48;   // U[38:0] * texture size
    localparam int LADDR_W  = 19;   // row * cols + tx before wrapping

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 32;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_AXIS_COS = 3'd2;
    localparam logic [2:0] REG_AXIS_SIN = 3'd3;
    localparam logic [2:0] REG_INV_W    = 3'd4;
    localparam logic [2:0] REG_INV_H    = 3'd5;
    localparam logic [2:0] REG_COLS     = 3'd6;
    localparam logic [2:0] REG_ROWS     = 3'd7;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SHADE = 1'b1;

    typedef struct packed {
        logic signed [16:0] origin_x;
        logic signed [16:0] origin_y;
        logic signed [15:0] axis_cos;
        logic signed [15:0] axis_sin;
        logic [20:0]        inv_quad_width;
        logic [20:0]        inv_quad_height;
        logic [8:0]         tex_cols;
        logic [8:0]         tex_rows;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_NOP       = 2'd0,
        OP_WRITE     = 2'd1,
        OP_SHADE_IN  = 2'd2,
        OP_SHADE_OUT = 2'd3
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // round((dst*(255-a) + src*a) / 255); x/255 = (x + (x>>8) + 1) >> 8 for x < 65535
    function automatic logic [7:0] blend_chan(input logic [7:0] dst, input logic [7:0] src,
                                              input logic [7:0] a);
        logic [15:0] n;
        logic [16:0] x;
        logic [16:0] q;
        n = 16'(dst * (8'd255 - a)) + 16'(src * a);
        x = {1'b0, n} + 17'd127;
        q = (x + (x >> 8) + 17'd1) >> 8;
        return q[7:0];
    endfunction

endpackage

@@ rtl/core/tqps_cfg.sv @@
// Configuration register file behind the APB-style port.
// Depends on tqps_pkg (cfg_t, register indexes).
module tqps_cfg
    import tqps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx = paddr[4:2];
    assign wr  = psel & penable & pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.axis_cos        <= 16'sd16384;
            cfg_reg.axis_sin        <= '0;
            cfg_reg.inv_quad_width  <= 21'd8192;
            cfg_reg.inv_quad_height <= 21'd8192;
            cfg_reg.tex_cols        <= 9'd128;
            cfg_reg.tex_rows        <= 9'd128;
        end else if (wr) begin
            case (idx)
                REG_ORIGIN_X: cfg_reg.origin_x        <= pwdata[16:0];
                REG_ORIGIN_Y: cfg_reg.origin_y        <= pwdata[16:0];
                REG_AXIS_COS: cfg_reg.axis_cos        <= pwdata[15:0];
                REG_AXIS_SIN: cfg_reg.axis_sin        <= pwdata[15:0];
                REG_INV_W:    cfg_reg.inv_quad_width  <= pwdata[20:0];
                REG_INV_H:    cfg_reg.inv_quad_height <= pwdata[20:0];
                REG_COLS:     cfg_reg.tex_cols        <= pwdata[8:0];
                REG_ROWS:     cfg_reg.tex_rows        <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ORIGIN_X: prdata = {15'd0, cfg_reg.origin_x};
            REG_ORIGIN_Y: prdata = {15'd0, cfg_reg.origin_y};
            REG_AXIS_COS: prdata = {16'd0, cfg_reg.axis_cos};
            REG_AXIS_SIN: prdata = {16'd0, cfg_reg.axis_sin};
            REG_INV_W:    prdata = {11'd0, cfg_reg.inv_quad_width};
            REG_INV_H:    prdata = {11'd0, cfg_reg.inv_quad_height};
            REG_COLS:     prdata = {23'd0, cfg_reg.tex_cols};
            REG_ROWS:     prdata = {23'd0, cfg_reg.tex_rows};
            default:      prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/tqps_front.sv @@
// Front pipeline: classify items, project pixels onto the quad, form texel addresses.
// Depends on tqps_pkg (cfg_t, op_t, width constants).
module tqps_front
    import tqps_pkg::*;
#(
    parameter int TEX_DEPTH  = TEX_DEPTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int ADDR_BITS = $clog2(TEX_DEPTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_kind,
    input  logic [13:0]          in_texel_addr,
    input  logic [31:0]          in_texel_word,
    input  logic [11:0]          in_pixel_x,
    input  logic [11:0]          in_pixel_y,
    input  logic [31:0]          in_old_color,
    input  logic                 q_full,
    output logic                 q_push,
    output op_t                  q_op,
    output logic [ADDR_BITS-1:0] q_addr,
    output logic [31:0]          q_word
);

    localparam int NST = 7;
    localparam logic [11:0] CMASK = 12'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic signed [UV_W-1:0] UV_ONE = UV_W'(64'd1 << UV_FRAC);

    logic [NST-1:0]         v_reg;
    op_t                    op_reg   [NST];
    logic [ADDR_BITS-1:0]   ladr_reg [NST];
    logic [31:0]            word_reg [NST];

    logic signed [DX_W-1:0]   dx_reg, dy_reg;
    logic signed [PROD_W-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [DUV_W-1:0]  du_reg, dv_reg;
    logic signed [UV_W-1:0]   u_reg, v_uv_reg;
    logic [TPROD_W-1:0]       tpx_reg, tpy_reg;
    logic [8:0]               tx_reg, tx2_reg, row_reg, row2_reg;

    logic                 adv;
    logic [8:0]           cols, rows;
    logic [15:0]          px16, py16;
    logic [31:0]          ladr_wide;
    op_t                  op_in;
    op_t                  op_mark;
    logic                 in_quad;
    logic [9:0]           ix, iy;
    logic [8:0]           tx_c, ty_c;
    logic [LADDR_W-1:0]   lin;
    logic [31:0]          lin_wide;

    assign cols = (cfg.tex_cols == 9'd0) ? 9'd1 : cfg.tex_cols;
    assign rows = (cfg.tex_rows == 9'd0) ? 9'd1 : cfg.tex_rows;

    // stall the whole pipe only when the last stage holds an item and the queue is full
    assign adv      = !(v_reg[NST-1] && q_full);
    assign in_ready = adv;

    assign px16      = {in_pixel_x & CMASK, 4'b0000};
    assign py16      = {in_pixel_y & CMASK, 4'b0000};
    assign ladr_wide = {18'd0, in_texel_addr};

    always_comb begin
        if (in_kind == KIND_SHADE) begin
            op_in = OP_SHADE_IN;
        end else if ({18'd0, in_texel_addr} < 32'(TEX_DEPTH)) begin
            op_in = OP_WRITE;
        end else begin
            op_in = OP_NOP;
        end
    end

    assign in_quad = !u_reg[UV_W-1] && (u_reg <= UV_ONE) &&
                     !v_uv_reg[UV_W-1] && (v_uv_reg <= UV_ONE);

    // mark pixels that miss the quad as they move into stage 4
    assign op_mark = (op_reg[3] == OP_SHADE_IN && !in_quad) ? OP_SHADE_OUT : op_reg[3];

    assign ix   = tpx_reg[TPROD_W-1:UV_FRAC];
    assign iy   = tpy_reg[TPROD_W-1:UV_FRAC];
    assign tx_c = (ix > {1'b0, cols - 9'd1}) ? cols - 9'd1 : ix[8:0];
    assign ty_c = (iy > {1'b0, rows - 9'd1}) ? rows - 9'd1 : iy[8:0];

    assign lin      = LADDR_W'(row2_reg * cols) + LADDR_W'(tx2_reg);
    assign lin_wide = {13'd0, lin};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg[0]   <= op_in;
            ladr_reg[0] <= ladr_wide[ADDR_BITS-1:0];
            word_reg[0] <= (in_kind == KIND_SHADE) ? in_old_color : in_texel_word;
            for (int i = 1; i < NST; i++) begin
                op_reg[i]   <= (i == 4) ? op_mark : op_reg[i-1];
                ladr_reg[i] <= ladr_reg[i-1];
                word_reg[i] <= word_reg[i-1];
            end

            dx_reg   <= $signed({2'b00, px16}) - DX_W'(cfg.origin_x);
            dy_reg   <= $signed({2'b00, py16}) - DX_W'(cfg.origin_y);
            pxc_reg  <= dx_reg * cfg.axis_cos;
            pys_reg  <= dy_reg * cfg.axis_sin;
            pyc_reg  <= dy_reg * cfg.axis_cos;
            pxs_reg  <= dx_reg * cfg.axis_sin;
            du_reg   <= DUV_W'(pxc_reg) + DUV_W'(pys_reg);
            dv_reg   <= DUV_W'(pyc_reg) - DUV_W'(pxs_reg);
            u_reg    <= du_reg * $signed({1'b0, cfg.inv_quad_width});
            v_uv_reg <= dv_reg * $signed({1'b0, cfg.inv_quad_height});
            tpx_reg  <= TPROD_W'(u_reg[UV_FRAC:0] * cols);
            tpy_reg  <= TPROD_W'(v_uv_reg[UV_FRAC:0] * rows);
            tx_reg   <= tx_c;
            row_reg  <= rows - 9'd1 - ty_c;
            tx2_reg  <= tx_reg;
            row2_reg <= row_reg;
        end
    end

    // row2_reg and tx2_reg line up with stage 6; the address is formed on the way out
    assign q_push = v_reg[NST-1] && adv;
    assign q_op   = op_reg[NST-1];
    assign q_word = word_reg[NST-1];
    assign q_addr = (op_reg[NST-1] == OP_WRITE) ? ladr_reg[NST-1]
                                                : lin_wide[ADDR_BITS-1:0];

endmodule

@@ rtl/core/tqps_queue.sv @@
// Short register FIFO that decouples the front pipeline from the texture back end.
// Depends on tqps_pkg (q_stat_t).
module tqps_queue
    import tqps_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH)
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output q_stat_t      stat
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign stat.full  = (cnt_reg == (PW+1)'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/tqps_back.sv @@
// Back end: texture store writes and reads, alpha blend, output register.
// Depends on tqps_pkg (op_t, blend_chan).
module tqps_back
    import tqps_pkg::*;
#(
    parameter int TEX_DEPTH  = TEX_DEPTH_DEF,
    localparam int ADDR_BITS = $clog2(TEX_DEPTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  op_t                  q_op,
    input  logic [ADDR_BITS-1:0] q_addr,
    input  logic [31:0]          q_word,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          out_color,
    output logic                 out_covered
);

    logic [31:0] tex_mem [TEX_DEPTH];
    logic [31:0] texel_reg;
    logic [31:0] old_reg;
    logic        b1_v_reg, b1_cov_reg;
    logic        ov_reg;
    logic [31:0] color_reg;
    logic        cov_reg;

    logic        adv;
    logic [7:0]  a;
    logic [31:0] blended;

    assign adv   = !ov_reg || out_ready;
    assign q_pop = adv && !q_empty;

    assign a       = texel_reg[31:24];
    assign blended = {a,
                      blend_chan(old_reg[23:16], texel_reg[23:16], a),
                      blend_chan(old_reg[15:8],  texel_reg[15:8],  a),
                      blend_chan(old_reg[7:0],   texel_reg[7:0],   a)};

    always_ff @(posedge aclk) begin
        if (q_pop && q_op == OP_WRITE) begin
            tex_mem[q_addr] <= q_word;
        end
        if (q_pop && q_op == OP_SHADE_IN) begin
            texel_reg <= tex_mem[q_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else if (adv) begin
            b1_v_reg <= q_pop && (q_op == OP_SHADE_IN || q_op == OP_SHADE_OUT);
            ov_reg   <= b1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            old_reg    <= q_word;
            b1_cov_reg <= (q_op == OP_SHADE_IN);
            color_reg  <= b1_cov_reg ? blended : old_reg;
            cov_reg    <= b1_cov_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign out_color   = color_reg;
    assign out_covered = cov_reg;

endmodule

@@ rtl/core/textured_quad_pixel_shader.sv @@
// Top level of the textured quad pixel shader: config port, front, queue, back end.
// Depends on tqps_pkg, tqps_cfg, tqps_front, tqps_queue, tqps_back.
//
// Streams one item per clock unless the front stalls on a full queue. A load item
// (tuser = 0) writes an ARGB texel to the texture store and gives no result; a shade
// item (tuser = 1) gives exactly one result transfer: the alpha-blended colour with
// covered set when the pixel lands in the rotated quad, else the old colour with covered
// clear. Results leave in item order. On its way to the result an item passes seven
// stages of projection and texel addressing in the front pipe, one queue slot, the
// registered texture read and the output register. A new item is taken every cycle
// unless that stall holds it; the four-entry queue lets the front keep going while the
// result side is briefly held. TEX_DEPTH must be a power of two (texel addresses wrap at
// the store size); there is no clearing pass, so every texel a shade item can reach must
// be loaded first. Write configuration only while no items are in flight.
module textured_quad_pixel_shader
    import tqps_pkg::*;
#(
    parameter int TEX_DEPTH  = TEX_DEPTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata, low bit first: texel_addr[13:0], texel_word[45:14], pixel_x[57:46],
    // pixel_y[69:58], old_color[101:70], zero pad[103:102]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,   // kind: 0 load, 1 shade
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // new_color[31:0]
    output logic [0:0]           m_tuser,   // covered
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CFG_AW-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int ADDR_BITS = $clog2(TEX_DEPTH);
    localparam int QW        = 2 + ADDR_BITS + 32;

    cfg_t                 cfg;
    logic                 q_push, q_pop;
    op_t                  f_op;
    logic [ADDR_BITS-1:0] f_addr;
    logic [31:0]          f_word;
    logic [QW-1:0]        q_rdata;
    q_stat_t              q_stat;
    logic                 m_covered;

    assign pready = 1'b1;

    tqps_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // front: project each pixel and turn it into a store access
    tqps_front #(
        .TEX_DEPTH  (TEX_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser[0]),
        .in_texel_addr (s_tdata[13:0]),
        .in_texel_word (s_tdata[45:14]),
        .in_pixel_x    (s_tdata[57:46]),
        .in_pixel_y    (s_tdata[69:58]),
        .in_old_color  (s_tdata[101:70]),
        .q_full        (q_stat.full),
        .q_push        (q_push),
        .q_op          (f_op),
        .q_addr        (f_addr),
        .q_word        (f_word)
    );

    // hold accesses in order so loads and shades hit the store as they arrived
    tqps_queue #(
        .W     (QW),
        .DEPTH (4)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({f_op, f_addr, f_word}),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    tqps_back #(
        .TEX_DEPTH (TEX_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_stat.empty),
        .q_op        (op_t'(q_rdata[QW-1 -: 2])),
        .q_addr      (q_rdata[32 +: ADDR_BITS]),
        .q_word      (q_rdata[31:0]),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_color   (m_tdata),
        .out_covered (m_covered)
    );

    assign m_tuser = m_covered;

    // never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // a result held by the sink keeps the queue from draining
    a_hold_blocks_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("queue drained while result stalled");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
